/* rtl/assert_macros.svh */
// Assertion macros for the RTL; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/ecsm_pkg.sv */
package ecsm_pkg;
  localparam int FieldBits = 32;
  localparam int ScalarBits = 32;
  localparam int InBits = 32;
  localparam logic [31:0] PrimeReset = 32'd132661;
  localparam logic [31:0] CurveAReset = 32'd62;

  typedef enum logic {
    REG_PRIME = 1'b0,
    REG_CURVE_A = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    MOP_MUL = 2'd0,
    MOP_RED = 2'd1
  } mop_t;

  typedef enum logic [4:0] {
    S_IDLE, S_REDX, S_REDY, S_REDA, S_BIT, S_CHK, S_SQ, S_ND, S_NA,
    S_INVSQ, S_INVMUL, S_LAM, S_LL, S_RY, S_UPD, S_NEXT, S_NEG, S_OUT
  } state_t;
endpackage

/* rtl/ecsm_modmul.sv */
// Bit-serial modular multiply (one multiplier bit per cycle), also reduces a
// raw value modulo p by multiplying it by one with the raw word fed MSB first.
module ecsm_modmul #(
  parameter int FIELD_BITS = ecsm_pkg::FieldBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ecsm_pkg::mop_t        op,
  input  logic [FIELD_BITS-1:0] u,
  input  logic [FIELD_BITS-1:0] v,
  input  logic [FIELD_BITS-1:0] p,
  output logic                  done,
  output logic [FIELD_BITS-1:0] r
);
  import ecsm_pkg::*;
  localparam int CW = $clog2(FIELD_BITS + 1);

  logic [FIELD_BITS-1:0] acc, uu, vv;
  logic [CW-1:0] cnt;
  logic busy, red;
  logic [FIELD_BITS:0] dbl, dbl_s, sum, sum_s;
  logic [FIELD_BITS-1:0] step1, addend;

  // For reduction: acc = 2*acc + bit, each kept below p.
  always_comb begin
    dbl = {acc, 1'b0} + {{FIELD_BITS{1'b0}}, red & vv[FIELD_BITS-1]};
    dbl_s = dbl - {1'b0, p};
    step1 = dbl_s[FIELD_BITS] ? dbl[FIELD_BITS-1:0] : dbl_s[FIELD_BITS-1:0];
    addend = (!red && vv[FIELD_BITS-1]) ? uu : '0;
    sum = {1'b0, step1} + {1'b0, addend};
    sum_s = sum - {1'b0, p};
    done = busy && (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(FIELD_BITS);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      uu <= u;
      vv <= v;
      red <= (op == MOP_RED);
    end else if (busy && cnt != '0) begin
      acc <= sum_s[FIELD_BITS] ? sum[FIELD_BITS-1:0] : sum_s[FIELD_BITS-1:0];
      vv <= {vv[FIELD_BITS-2:0], 1'b0};
    end
  end
  assign r = acc;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_mm_load, clk, rst, start, busy && cnt == CW'(FIELD_BITS))
  `ASSERT_IMPLIES(a_mm_below, clk, rst, busy && p != '0 && cnt != CW'(FIELD_BITS), acc < p)
  `ASSERT_NEXT(a_mm_end, clk, rst, done && !start, !busy)
endmodule

/* rtl/ec_scalar_multiply.sv */
// Run time depends on the data: a full point operation is an inverse by FIELD_BITS
// square/multiply pairs plus up to four multiplies, and each scalar bit takes up to
// two point operations. One word in flight at a time: a new word is taken once the
// result left.
// Reset: rst synchronous, active high; registers return to p=132661, a=62.
module ec_scalar_multiply #(
  parameter int FIELD_BITS = ecsm_pkg::FieldBits,
  parameter int SCALAR_BITS = ecsm_pkg::ScalarBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: point_x[31:0], point_y[63:32], scalar[96:64], zero pad [103:97]
  input  logic [103:0] s_tdata,
  // tuser: point_is_infinity
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: result_x[31:0], result_y[63:32]
  output logic [63:0] m_tdata,
  // tuser: result_is_infinity
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import ecsm_pkg::*;
  localparam int FB = FIELD_BITS;
  localparam int SB = SCALAR_BITS;
  localparam int SW = $clog2(SB + 1);
  localparam int EW = $clog2(FB + 1);

  logic [FB-1:0] prime, ca;
  state_t state, state_next;

  // Working registers.
  logic [InBits-1:0] ex, ey;
  logic [FB-1:0] bx, by, ix, qx, qy, ta, ty, lam, num, den, inv, ee;
  logic binf, qinf, neg, isadd, usedbl, addbit;
  logic [SB-1:0] mag;
  logic [SW-1:0] bi;
  logic [EW-1:0] ei;
  logic [FB-1:0] p_eff;

  // Multiplier port.
  logic mm_start, mm_done;
  mop_t mm_op;
  logic [FB-1:0] mm_u, mm_v, mm_r;
  logic started;

  ecsm_modmul #(.FIELD_BITS(FB)) u_mul (
    .clk, .rst, .start(mm_start), .op(mm_op), .u(mm_u), .v(mm_v),
    .p(p_eff), .done(mm_done), .r(mm_r)
  );

  // A zero modulus acts as modulus one: every coordinate collapses to zero.
  assign p_eff = (prime == '0) ? FB'(1) : prime;

  function automatic logic [FB-1:0] fadd(input logic [FB-1:0] x, y, m);
    logic [FB:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, m}) ? FB'(s - {1'b0, m}) : s[FB-1:0];
  endfunction
  function automatic logic [FB-1:0] fsub(input logic [FB-1:0] x, y, m);
    return (x >= y) ? x - y : x - y + m;
  endfunction

  // Config writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= FB'(PrimeReset);
      ca <= FB'(CurveAReset);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRIME: prime <= FB'(cfg_data);
        REG_CURVE_A: ca <= FB'(cfg_data);
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {32'(qy), 32'(qx)};
  assign m_tuser = qinf;

  // Sequencer: mm_start fires once per multiplier-using state, on entry (S_INVMUL
  // only on a set exponent bit); the state advances when the multiplier reports done.
  always_comb begin
    state_next = state;
    mm_start = 1'b0;
    mm_op = MOP_MUL;
    mm_u = '0;
    mm_v = '0;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_REDX;
      S_REDX: begin
        mm_op = MOP_RED; mm_v = FB'(ex); mm_start = !started;
        if (mm_done) state_next = S_REDY;
      end
      S_REDY: begin
        mm_op = MOP_RED; mm_v = FB'(ey); mm_start = !started;
        if (mm_done) state_next = S_REDA;
      end
      S_REDA: begin
        mm_op = MOP_RED; mm_v = ca; mm_start = !started;
        if (mm_done) state_next = S_BIT;
      end
      S_BIT: state_next = (bi == '0) ? S_NEG : S_CHK;
      S_CHK: begin
        // Pick the trivial outcomes off before any field arithmetic.
        if (isadd) begin
          if (binf || qinf) state_next = S_NEXT;
          else if (qx != bx) state_next = S_ND;
          else if (qy == by && qy != '0) state_next = S_SQ;
          else state_next = S_NEXT;
        end else begin
          if (qinf || qy == '0) state_next = S_NEXT;
          else state_next = S_SQ;
        end
      end
      S_SQ: begin
        mm_u = qx; mm_v = qx; mm_start = !started;
        if (mm_done) state_next = S_ND;
      end
      S_ND: state_next = S_NA;
      S_NA: state_next = S_INVSQ;
      S_INVSQ: begin
        mm_u = inv; mm_v = inv; mm_start = !started;
        if (mm_done) state_next = S_INVMUL;
      end
      S_INVMUL: begin
        mm_u = inv; mm_v = den; mm_start = !started && ee[FB-1];
        if (!ee[FB-1] || mm_done) state_next = (ei == EW'(1)) ? S_LAM : S_INVSQ;
      end
      S_LAM: begin
        mm_u = num; mm_v = inv; mm_start = !started;
        if (mm_done) state_next = S_LL;
      end
      S_LL: begin
        mm_u = lam; mm_v = lam; mm_start = !started;
        if (mm_done) state_next = S_RY;
      end
      S_RY: begin
        mm_u = lam; mm_v = fsub(qx, ta, p_eff); mm_start = !started;
        if (mm_done) state_next = S_UPD;
      end
      S_UPD: state_next = S_NEXT;
      S_NEXT: state_next = (!isadd && addbit) ? S_CHK : S_BIT;
      S_NEG: state_next = S_OUT;
      S_OUT: if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      started <= mm_done ? 1'b0 : (started || mm_start);
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (s_tvalid) begin
        ex <= s_tdata[31:0];
        ey <= s_tdata[63:32];
        binf <= s_tuser;
        neg <= s_tdata[96];
        mag <= SB'(s_tdata[96] ? (33'd0 - s_tdata[96:64]) : s_tdata[96:64]);
        bi <= SW'(SB);
        qinf <= 1'b1; qx <= '0; qy <= '0;
      end
      S_REDX: if (mm_done) bx <= mm_r;
      S_REDY: if (mm_done) by <= mm_r;
      S_REDA: if (mm_done) ix <= mm_r;
      S_BIT: if (bi != '0) begin
        // Advance to the next scalar bit, MSB first; double comes before add.
        bi <= bi - 1'b1;
        addbit <= mag[SB-1];
        mag <= {mag[SB-2:0], 1'b0};
        isadd <= 1'b0;
      end
      S_CHK: begin
        if (isadd) begin
          if (!binf) begin
            if (qinf) begin
              qx <= bx; qy <= by; qinf <= 1'b0;
            end else if (qx != bx) begin
              usedbl <= 1'b0;
            end else if (qy == by && qy != '0) begin
              usedbl <= 1'b1;
            end else begin
              // P + (-P): drop to infinity
              qinf <= 1'b1; qx <= '0; qy <= '0;
            end
          end
        end else if (!qinf) begin
          if (qy == '0) begin
            qinf <= 1'b1; qx <= '0;
          end else begin
            usedbl <= 1'b1;
          end
        end
      end
      S_SQ: if (mm_done) ta <= mm_r;
      S_ND: begin
        num <= usedbl ? fadd(fadd(ta, ta, p_eff), ta, p_eff) : fsub(by, qy, p_eff);
        den <= usedbl ? fadd(qy, qy, p_eff) : fsub(bx, qx, p_eff);
      end
      S_NA: begin
        if (usedbl) num <= fadd(num, ix, p_eff);
        // Inverse of zero is zero: start the power chain from zero then.
        inv <= (den == '0) ? '0 : FB'(1);
        ee <= p_eff - FB'(2);
        ei <= EW'(FB);
      end
      S_INVSQ: if (mm_done) inv <= mm_r;
      S_INVMUL: if (!ee[FB-1] || mm_done) begin
        if (ee[FB-1]) inv <= mm_r;
        ee <= {ee[FB-2:0], 1'b0};
        ei <= ei - 1'b1;
      end
      S_LAM: if (mm_done) lam <= mm_r;
      S_LL: if (mm_done) ta <= fsub(fsub(mm_r, qx, p_eff), usedbl ? qx : bx, p_eff);
      S_RY: if (mm_done) ty <= mm_r;
      S_UPD: begin
        qx <= ta;
        qy <= fsub(ty, qy, p_eff);
      end
      S_NEXT: if (!isadd && addbit) isadd <= 1'b1;
      S_NEG: if (qinf) begin
        qx <= '0; qy <= '0;
      end else if (neg) qy <= fsub('0, qy, p_eff);
      default: ;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_accept_busy, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `ASSERT_IMPLIES(a_inf_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  `ASSERT_IMPLIES(a_one_side, clk, rst, s_tready, !m_tvalid)
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ecsm_pkg::*;

  localparam int  CycleLimit = 80_000_000;
  localparam int  HoldOffCycles = 200_000;
  localparam int  DrainCycles = 200;
  localparam int  ItemsPerSetting = 20;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    logic        inf;
  } point_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        inf;
    logic [32:0] k;
    logic        typed;
    point_t      want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // tdata: point_x[31:0], point_y[63:32], scalar[96:64], zero pad [103:97]
  logic [103:0] s_tdata = '0;
  // tuser: point_is_infinity
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // tdata: result_x[31:0], result_y[63:32]
  logic [63:0]  m_tdata;
  // tuser: result_is_infinity
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_data = '0;

  // Shadow copy of the configuration registers
  logic [63:0]  prime_q = 64'(PrimeReset);
  logic [63:0]  curve_a_q = 64'(CurveAReset);

  point_t       pending_products[$];
  int           mismatches = 0;
  int           products_seen = 0;
  int           cycle_count = 0;
  stim_row_t    directed_rows[$];

  ec_scalar_multiply uut (.*);

  always #5 clk = ~clk;

  // Guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("cycle limit reached");
      $display("ec_scalar_multiply regression: fail");
      $finish;
    end
  end

  // ---- field and curve arithmetic, operands always in [0, p) ----
  function automatic logic [63:0] fe_add(logic [63:0] u, logic [63:0] v, logic [63:0] p);
    return (u >= p - v) ? u - (p - v) : u + v;
  endfunction

  function automatic logic [63:0] fe_sub(logic [63:0] u, logic [63:0] v, logic [63:0] p);
    return (u >= v) ? u - v : (u - v) + p;
  endfunction

  function automatic logic [63:0] fe_mul(logic [63:0] u, logic [63:0] v, logic [63:0] p);
    logic [63:0] r;
    r = 0;
    for (int i = FieldBits - 1; i >= 0; i--) begin
      r = fe_add(r, r, p);
      if (v[i]) r = fe_add(r, u, p);
    end
    return r;
  endfunction

  // Fermat inverse; zero and a degenerate modulus give zero
  function automatic logic [63:0] fe_inv(logic [63:0] v, logic [63:0] p);
    logic [63:0] e;
    logic [63:0] r;
    if (v == 0 || p < 2) return 0;
    e = p - 2;
    r = 1 % p;
    for (int i = FieldBits - 1; i >= 0; i--) begin
      r = fe_mul(r, r, p);
      if (e[i]) r = fe_mul(r, v, p);
    end
    return r;
  endfunction

  function automatic point_t point_sum(point_t s, point_t t, logic [63:0] a, logic [63:0] p);
    point_t      r;
    logic [63:0] lam;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] sq;
    logic [63:0] rx;
    if (t.inf) return s;
    if (s.inf) return t;
    r = '{x: 64'd0, y: 64'd0, inf: 1'b1};
    if (s.x != t.x) begin
      num = fe_sub(t.y, s.y, p);
      den = fe_sub(t.x, s.x, p);
    end else if (s.y == t.y && s.y != 0) begin
      sq = fe_mul(s.x, s.x, p);
      num = fe_add(fe_add(fe_add(sq, sq, p), sq, p), a, p);
      den = fe_add(s.y, s.y, p);
    end else begin
      // P + (-P), or doubling a point with y zero
      return r;
    end
    lam = fe_mul(num, fe_inv(den, p), p);
    rx = fe_sub(fe_sub(fe_mul(lam, lam, p), s.x, p), t.x, p);
    r.x = rx;
    r.y = fe_sub(fe_mul(lam, fe_sub(s.x, rx, p), p), s.y, p);
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic point_t scalar_product(logic [31:0] x, logic [31:0] y, logic inf,
                                            logic [32:0] k);
    logic [63:0] p;
    logic [63:0] a;
    logic [32:0] mag;
    point_t      base;
    point_t      q;
    p = (prime_q == 0) ? 64'd1 : prime_q;
    a = curve_a_q % p;
    mag = k[32] ? (~k + 33'd1) : k;
    mag[32] = 1'b0;  // only the low scalar bits count
    base = '{x: 64'(x) % p, y: 64'(y) % p, inf: inf};
    q = '{x: 64'd0, y: 64'd0, inf: 1'b1};
    for (int i = ScalarBits - 1; i >= 0; i--) begin
      q = point_sum(q, q, a, p);
      if (mag[i]) q = point_sum(q, base, a, p);
    end
    if (q.inf) begin
      q.x = 0;
      q.y = 0;
    end else if (k[32]) begin
      q.y = fe_sub(64'd0, q.y, p);
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PRIME) prime_q = 64'(value);
    else curve_a_q = 64'(value);
  endtask

  // Offer one word after a random gap; keep tvalid high across back-to-back words
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic inf, logic [32:0] k,
                            logic typed, point_t want);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, k, y, x};
    s_tuser <= inf;
    do @(posedge clk); while (!s_tready);
    // Word accepted at this edge: record what must come back
    pending_products.push_back(typed ? want : scalar_product(x, y, inf, k));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    wait (pending_products.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic inf, logic [32:0] k,
                         logic typed, logic [31:0] wx, logic [31:0] wy, logic winf);
    directed_rows.push_back('{x: x, y: y, inf: inf, k: k, typed: typed,
                              want: '{x: 64'(wx), y: 64'(wy), inf: winf}});
  endtask

  // Result side: random stalls, one long hold-off to back up the input
  initial begin : result_sink
    int     stall;
    point_t want;
    @(negedge rst);
    forever begin
      stall = (products_seen == 15) ? HoldOffCycles : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      products_seen++;
      if (pending_products.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
      end else begin
        want = pending_products.pop_front();
        if (64'(m_tdata[31:0]) != want.x)
          report_mismatch("result_x", m_tdata[31:0], want.x[31:0]);
        if (64'(m_tdata[63:32]) != want.y)
          report_mismatch("result_y", m_tdata[63:32], want.y[31:0]);
        if (m_tuser != want.inf)
          report_mismatch("result_is_infinity", 32'(m_tuser), 32'(want.inf));
      end
    end
  end

  initial begin : stimulus
    logic [63:0] phase_cfg [5][2];
    logic [31:0] mag;
    logic [32:0] k;
    point_t      none;
    none = '{x: 64'd0, y: 64'd0, inf: 1'b0};

    // x, y, infinity, scalar, typed expectation
    add_row(5, 7, 0, 33'd0, 1, 0, 0, 1);                  // zero scalar
    add_row(9, 4, 1, 33'd12345, 1, 0, 0, 1);              // infinite base
    add_row(9, 4, 1, -33'sd1, 1, 0, 0, 1);
    add_row(11, 13, 0, 33'h1_0000_0000, 1, 0, 0, 1);      // magnitude wraps to zero
    add_row(3, 0, 0, 33'd2, 1, 0, 0, 1);                  // doubling with y zero
    add_row(3, 0, 0, -33'sd2, 1, 0, 0, 1);
    add_row(0, 0, 0, 33'd1, 1, 0, 0, 0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 33'd1, 0, 0, 0, 0);
    add_row(10, 20, 0, -33'sd1, 0, 0, 0, 0);
    add_row(1, 2, 0, 33'd3, 0, 0, 0, 0);
    add_row(1, 2, 0, 33'd6, 0, 0, 0, 0);
    add_row(32'h1234_5678, 32'h0ABC_DEF0, 0, 33'h0_FFFF_FFFF, 0, 0, 0, 0);
    add_row(32'h8765_4321, 32'h0F0F_0F0F, 0, 33'h1_0000_0001, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].inf,
                 directed_rows[i].k, directed_rows[i].typed, directed_rows[i].want);

    phase_cfg[0] = '{64'd4294967291, 64'd4294967290};
    phase_cfg[1] = '{64'd3, 64'd0};
    phase_cfg[2] = '{64'd0, 64'd7};
    phase_cfg[3] = '{64'd15, 64'd4294967290};
    phase_cfg[4] = '{64'd10007, 64'($urandom)};

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_register(REG_PRIME, phase_cfg[ph][0][31:0]);
      write_register(REG_CURVE_A, phase_cfg[ph][1][31:0]);
      for (int n = 0; n < ItemsPerSetting; n++) begin
        // Any affine pair lies on some curve, so random points are well formed.
        // Keep most scalars short: the block runs long on wide ones.
        if ($urandom_range(0, 24) == 0) begin
          k = {1'($urandom_range(0, 1)), 32'($urandom)};
        end else begin
          mag = 32'($urandom_range(0, 255));
          k = $urandom_range(0, 1) ? -{1'b0, mag} : {1'b0, mag};
        end
        send_point($urandom, $urandom, $urandom_range(0, 15) == 0, k, 1'b0, none);
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("ec_scalar_multiply regression: pass");
    end else begin
      $display("ec_scalar_multiply regression: fail");
    end
    $finish;
  end

endmodule
